### hw/rtl/pdtf_pkg.sv
// Shared types, constants and helpers for the PD tape follower.
`timescale 1ns / 1ps
`default_nettype none

package pdtf_pkg;

    localparam int CNT_BITS    = 16;
    localparam int NUM_BITS    = 12;
    localparam int STEP_BITS   = $clog2(NUM_BITS);
    localparam int SAMPLE_BITS = 10;
    localparam int GAIN_BITS   = 8;
    localparam int ERR_BITS    = 4;
    localparam int DRIVE_BITS  = 9;
    localparam int SUM_BITS    = 15;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 10;
    localparam int IN_TDATA_BITS  = 24;
    localparam int OUT_TDATA_BITS = 24;

    localparam int DRIVE_LIMIT = 255;
    localparam int LOST_FACTOR = 5;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_BASE      = 2'd1,
        CFG_KP        = 2'd2,
        CFG_KD        = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic signed [DRIVE_BITS-1:0] clamp_drive(
        input logic signed [SUM_BITS-1:0] v
    );
        logic signed [DRIVE_BITS-1:0] res;
        if (v > SUM_BITS'(DRIVE_LIMIT)) begin
            res = DRIVE_BITS'(DRIVE_LIMIT);
        end else if (v < -SUM_BITS'(DRIVE_LIMIT)) begin
            res = -DRIVE_BITS'(DRIVE_LIMIT);
        end else begin
            res = v[DRIVE_BITS-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/pdtf_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module pdtf_divider (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire pdtf_pkg::t_div_ctl            i_ctl,
    input  wire logic [pdtf_pkg::NUM_BITS-1:0] i_dividend,
    input  wire logic [pdtf_pkg::CNT_BITS-1:0] i_divisor,
    output pdtf_pkg::t_div_stat                o_stat,
    output logic [pdtf_pkg::NUM_BITS-1:0]      o_quotient
);
    import pdtf_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [STEP_BITS-1:0] r_step, n_step;
    logic [NUM_BITS-1:0]  r_num, n_num;
    logic [CNT_BITS-1:0]  r_rem, n_rem;
    logic [CNT_BITS-1:0]  r_den, n_den;

    logic [CNT_BITS:0] w_trial;
    logic [CNT_BITS:0] w_diff;
    logic              w_ge;

    assign w_trial = {r_rem, r_num[NUM_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_num  = i_dividend;
            n_rem  = '0;
            n_den  = i_divisor;
        end else if (r_busy) begin
            n_num  = {r_num[NUM_BITS-2:0], w_ge};
            n_rem  = w_ge ? w_diff[CNT_BITS-1:0] : w_trial[CNT_BITS-1:0];
            n_step = r_step + 1'b1;
            if (r_step == STEP_BITS'(NUM_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_num;

endmodule

`default_nettype wire

### hw/rtl/pd_tape_follower_top.sv
// Top level of the PD tape follower: error forming, sequencer and output stage.
// Flow: an input beat is accepted in IDLE, the 12-step serial divider that forms the
//   derivative term runs in DIV, and the result beat is registered from DONE.
// The input is not ready while an item is in work, so items do not overlap.
// Reset: synchronous active-low; clears config, state, valid, error history and hold count.
`timescale 1ns / 1ps
`default_nettype none

module pd_tape_follower_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [pdtf_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire logic [pdtf_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // [9:0] right_sample, [19:10] left_sample
    input  wire logic [pdtf_pkg::IN_TDATA_BITS-1:0]  i_s_tdata,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // [8:0] right_drive, [17:9] left_drive, [21:18] track_error
    output logic [pdtf_pkg::OUT_TDATA_BITS-1:0]      o_m_tdata
);
    import pdtf_pkg::*;

    logic [SAMPLE_BITS-1:0] r_threshold;
    logic [GAIN_BITS-1:0]   r_base, r_kp, r_kd;

    t_state r_state, n_state;

    logic signed [ERR_BITS-1:0] r_prev_error, r_ref_error, r_err;
    logic signed [1:0]          r_last_side;
    logic [CNT_BITS-1:0]        r_hold_count;
    logic signed [12:0]         r_p;
    logic                       r_neg;

    logic                          r_m_valid;
    logic signed [DRIVE_BITS-1:0]  r_right_drive, r_left_drive;
    logic signed [ERR_BITS-1:0]    r_track_error;

    logic [SAMPLE_BITS-1:0]     w_rs, w_ls;
    logic                       w_r_off, w_l_off, w_both_on;
    logic signed [ERR_BITS-1:0] w_err, w_ref_eff;
    logic signed [4:0]          w_diff;
    logic [3:0]                 w_diff_mag;
    logic [NUM_BITS-1:0]        w_num;
    logic signed [12:0]         w_p;
    logic [CNT_BITS-1:0]        w_divisor;
    logic                       w_accept, w_load;

    t_div_ctl            w_div_ctl;
    t_div_stat           w_div_stat;
    logic [NUM_BITS-1:0] w_quot;

    logic signed [12:0]         w_d;
    logic signed [SUM_BITS-1:0] w_corr, w_rsum, w_lsum;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_base      <= '0;
            r_kp        <= '0;
            r_kd        <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                CFG_BASE:      r_base      <= i_cfg_data[GAIN_BITS-1:0];
                CFG_KP:        r_kp        <= i_cfg_data[GAIN_BITS-1:0];
                CFG_KD:        r_kd        <= i_cfg_data[GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // error forming
    assign w_rs      = i_s_tdata[SAMPLE_BITS-1:0];
    assign w_ls      = i_s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign w_r_off   = (w_rs < r_threshold);
    assign w_l_off   = (w_ls < r_threshold);
    assign w_both_on = !w_r_off && !w_l_off;

    always_comb begin
        if (w_both_on) begin
            w_err = '0;
        end else if (!w_r_off) begin
            w_err = -ERR_BITS'(1);
        end else if (!w_l_off) begin
            w_err = ERR_BITS'(1);
        end else if (r_last_side == -2'sd1) begin
            w_err = -ERR_BITS'(LOST_FACTOR);
        end else if (r_last_side == 2'sd1) begin
            w_err = ERR_BITS'(LOST_FACTOR);
        end else begin
            w_err = '0;
        end
    end

    assign w_ref_eff  = w_both_on ? '0 : r_ref_error;
    assign w_diff     = 5'(w_err) - 5'(w_ref_eff);
    assign w_diff_mag = w_diff[4] ? 4'(-w_diff) : w_diff[3:0];
    assign w_num      = NUM_BITS'(r_kd) * NUM_BITS'(w_diff_mag);
    assign w_p        = 13'(signed'({1'b0, r_kp})) * 13'(w_err);
    assign w_divisor  = (r_hold_count == '0) ? CNT_BITS'(1) : r_hold_count;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_load     = (r_state == ST_DONE) && (!r_m_valid || i_m_tready);

    assign w_div_ctl.start = w_accept;

    pdtf_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_div_ctl),
        .i_dividend (w_num),
        .i_divisor  (w_divisor),
        .o_stat     (w_div_stat),
        .o_quotient (w_quot)
    );

    // drive sums
    assign w_d    = r_neg ? -signed'({1'b0, w_quot}) : signed'({1'b0, w_quot});
    assign w_corr = SUM_BITS'(r_p) + SUM_BITS'(w_d);
    assign w_rsum = w_corr + SUM_BITS'(signed'({1'b0, r_base}));
    assign w_lsum = w_corr - SUM_BITS'(signed'({1'b0, r_base}));

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_DIV;
            ST_DIV:  if (w_div_stat.done) n_state = ST_DONE;
            ST_DONE: if (w_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // error history and per-item registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_error <= '0;
            r_ref_error  <= '0;
            r_last_side  <= '0;
            r_hold_count <= '0;
        end else if (w_accept) begin
            if (w_both_on) begin
                r_ref_error <= '0;
            end else if (!w_r_off) begin
                r_last_side <= -2'sd1;
            end else if (!w_l_off) begin
                r_last_side <= 2'sd1;
            end
        end else if (w_load) begin
            r_prev_error <= r_err;
            if (r_err != r_prev_error) begin
                r_ref_error  <= r_prev_error;
                r_hold_count <= CNT_BITS'(1);
            end else if (r_hold_count != '1) begin
                r_hold_count <= r_hold_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_err <= w_err;
            r_p   <= w_p;
            r_neg <= w_diff[4];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
        if (w_load) begin
            r_right_drive <= clamp_drive(w_rsum);
            r_left_drive  <= clamp_drive(w_lsum);
            r_track_error <= r_err;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {2'b00, r_track_error, r_left_drive, r_right_drive};

    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_DIV) && w_div_stat.busy)
        else $error("divider not started on input beat");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == ST_DIV))
        else $error("divider finished outside divide state");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> (r_track_error >= -4'sd5) && (r_track_error <= 4'sd5))
        else $error("track error out of range");

    a_hold_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_hold_count != '0))
        else $error("hold count zero after result");

endmodule

`default_nettype wire

### bench/pd_tape_follower_top_test.sv
// Self-checking testbench for pd_tape_follower_top: directed table, random phases, steady run.
`timescale 1ns / 1ps

module pd_tape_follower_top_test;
    import pdtf_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam longint HOLD_MAX = (longint'(1) << CNT_BITS) - 1;
    localparam int SOAK_ITEMS = 40;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 160;

    typedef struct packed {
        logic [ERR_BITS-1:0]   track_error;
        logic [DRIVE_BITS-1:0] left_drive;
        logic [DRIVE_BITS-1:0] right_drive;
    } t_motor_cmd;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // ROW_CFG: a = register, b = value; ROW_ITEM: a = right sample, b = left sample
    typedef struct packed {
        t_row_kind             kind;
        logic [9:0]            a;
        logic [9:0]            b;
        logic                  known;
        logic [DRIVE_BITS-1:0] rd;
        logic [DRIVE_BITS-1:0] ld;
        logic [ERR_BITS-1:0]   er;
    } t_stim_row;

    localparam int DIR_ROWS = 39;

    t_stim_row dir_rows [0:DIR_ROWS-1] = '{
        '{ROW_CFG,  CFG_THRESHOLD, 10'd512,  1'b0, 9'd0, 9'd0, 4'd0},
        '{ROW_CFG,  CFG_KD,        10'd255,  1'b0, 9'd0, 9'd0, 4'd0},
        // zero hold count divides as one; base and kp still at reset
        '{ROW_ITEM, 10'd1023, 10'd0,    1'b1, -9'sd255, -9'sd255, -4'sd1},
        '{ROW_ITEM, 10'd1023, 10'd0,    1'b0, 9'd0, 9'd0, 4'd0},
        // upper data bits are dropped for 8-bit registers
        '{ROW_CFG,  CFG_BASE,      10'h3FF,  1'b0, 9'd0, 9'd0, 4'd0},
        '{ROW_CFG,  CFG_KP,        10'd255,  1'b0, 9'd0, 9'd0, 4'd0},
        '{ROW_ITEM, 10'd511,  10'd511,  1'b0, 9'd0, 9'd0, 4'd0},
        '{ROW_ITEM, 10'd512,  10'd512,  1'b1, 9'sd255, -9'sd255, 4'sd0},
        '{ROW_ITEM, 10'd0,    10'd1023, 1'b0, 9'd0, 9'd0, 4'd0},
        '{ROW_ITEM, 10'd0,    10'd0,    1'b0, 9'd0, 9'd0, 4'd0},
        '{ROW_ITEM, 10'd511,  10'd512,  1'b0, 9'd0, 9'd0, 4'd0},
        '{ROW_ITEM, 10'd512,  10'd511,  1'b0, 9'd0, 9'd0, 4'd0},
        '{ROW_ITEM, 10'd1023, 10'd1023, 1'b1, 9'sd255, -9'sd255, 4'sd0},
        '{ROW_ITEM, 10'd1023, 10'd1023, 1'b1, 9'sd255, -9'sd255, 4'sd0},
        '{ROW_CFG,  CFG_THRESHOLD, 10'd1023, 1'b0, 9'd0, 9'd0, 4'd0},
        '{ROW_CFG,  CFG_BASE,      10'd0,    1'b0, 9'd0, 9'd0, 4'd0},
        '{ROW_CFG,  CFG_KP,        10'd0,    1'b0, 9'd0, 9'd0, 4'd0},
        '{ROW_CFG,  CFG_KD,        10'd0,    1'b0, 9'd0, 9'd0, 4'd0},
        '{ROW_ITEM, 10'd1023, 10'd1023, 1'b1, 9'sd0, 9'sd0, 4'sd0},
        '{ROW_ITEM, 10'd1022, 10'd1023, 1'b1, 9'sd0, 9'sd0, 4'sd1},
        '{ROW_ITEM, 10'd1023, 10'd1022, 1'b1, 9'sd0, 9'sd0, -4'sd1},
        '{ROW_ITEM, 10'd1022, 10'd1022, 1'b1, 9'sd0, 9'sd0, -4'sd5},
        '{ROW_ITEM, 10'd0,    10'd0,    1'b1, 9'sd0, 9'sd0, -4'sd5},
        '{ROW_CFG,  CFG_THRESHOLD, 10'd0,    1'b0, 9'd0, 9'd0, 4'd0},
        '{ROW_CFG,  CFG_BASE,      10'd128,  1'b0, 9'd0, 9'd0, 4'd0},
        '{ROW_CFG,  CFG_KP,        10'd7,    1'b0, 9'd0, 9'd0, 4'd0},
        '{ROW_CFG,  CFG_KD,        10'd3,    1'b0, 9'd0, 9'd0, 4'd0},
        '{ROW_ITEM, 10'd0,    10'd0,    1'b1, 9'sd128, -9'sd128, 4'sd0},
        '{ROW_ITEM, 10'd0,    10'd1023, 1'b1, 9'sd128, -9'sd128, 4'sd0},
        '{ROW_ITEM, 10'd1023, 10'd0,    1'b1, 9'sd128, -9'sd128, 4'sd0},
        '{ROW_CFG,  CFG_THRESHOLD, 10'd300,  1'b0, 9'd0, 9'd0, 4'd0},
        '{ROW_CFG,  CFG_BASE,      10'd60,   1'b0, 9'd0, 9'd0, 4'd0},
        '{ROW_CFG,  CFG_KP,        10'd30,   1'b0, 9'd0, 9'd0, 4'd0},
        '{ROW_CFG,  CFG_KD,        10'd90,   1'b0, 9'd0, 9'd0, 4'd0},
        '{ROW_ITEM, 10'd299,  10'd700,  1'b0, 9'd0, 9'd0, 4'd0},
        '{ROW_ITEM, 10'd299,  10'd700,  1'b0, 9'd0, 9'd0, 4'd0},
        '{ROW_ITEM, 10'd299,  10'd700,  1'b0, 9'd0, 9'd0, 4'd0},
        '{ROW_ITEM, 10'd700,  10'd299,  1'b0, 9'd0, 9'd0, 4'd0},
        '{ROW_ITEM, 10'd100,  10'd100,  1'b0, 9'd0, 9'd0, 4'd0}
    };

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_IDX_BITS-1:0]   i_cfg_idx;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;
    logic                      i_s_tvalid;
    logic                      o_s_tready;
    logic [IN_TDATA_BITS-1:0]  i_s_tdata;
    logic                      o_m_tvalid;
    logic                      i_m_tready;
    logic [OUT_TDATA_BITS-1:0] o_m_tdata;

    pd_tape_follower_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #2 i_clk = ~i_clk;

    // register mirror and controller state
    logic [SAMPLE_BITS-1:0] thr_q;
    logic [GAIN_BITS-1:0]   base_q;
    logic [GAIN_BITS-1:0]   kp_q;
    logic [GAIN_BITS-1:0]   kd_q;
    int                     prev_err;
    int                     ref_err;
    int                     last_side;
    longint                 hold_cnt;

    t_motor_cmd pending_cmds [$];
    bit         failed = 1'b0;
    bit         src_idle_en;
    bit         snk_stall_en;
    int         stall_left;
    int         quiet_cycles = 0;
    t_motor_cmd got_cmd;
    t_motor_cmd want_cmd;

    function automatic int clip_drive(input int v);
        if (v > DRIVE_LIMIT) return DRIVE_LIMIT;
        if (v < -DRIVE_LIMIT) return -DRIVE_LIMIT;
        return v;
    endfunction

    function automatic t_motor_cmd follow_step(input logic [SAMPLE_BITS-1:0] rs,
                                               input logic [SAMPLE_BITS-1:0] ls);
        t_motor_cmd cmd;
        bit r_off;
        bit l_off;
        int err;
        int p_term;
        int d_term;
        int divisor;
        r_off = rs < thr_q;
        l_off = ls < thr_q;
        if (!r_off && !l_off) begin
            err = 0;
            ref_err = 0;
        end else if (!r_off) begin
            err = -1;
            last_side = -1;
        end else if (!l_off) begin
            err = 1;
            last_side = 1;
        end else begin
            err = last_side * LOST_FACTOR;
        end
        divisor = (hold_cnt == 0) ? 1 : int'(hold_cnt);
        p_term = int'(kp_q) * err;
        d_term = (int'(kd_q) * (err - ref_err)) / divisor;
        cmd.right_drive = DRIVE_BITS'(clip_drive(int'(base_q) + p_term + d_term));
        cmd.left_drive  = DRIVE_BITS'(clip_drive(-int'(base_q) + p_term + d_term));
        cmd.track_error = ERR_BITS'(err);
        if (err != prev_err) begin
            ref_err = prev_err;
            hold_cnt = 0;
        end
        prev_err = err;
        if (hold_cnt < HOLD_MAX) hold_cnt++;
        return cmd;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input bit off);
        if (off && thr_q != 0) return SAMPLE_BITS'($urandom_range(int'(thr_q) - 1, 0));
        return SAMPLE_BITS'($urandom_range(1023, int'(thr_q)));
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_reg(input int max_val);
        int sel;
        int val;
        sel = $urandom_range(0, 3);
        val = (sel == 0) ? 0 : (sel == 1) ? max_val : $urandom_range(0, max_val);
        // stray upper bits on narrow registers must be ignored
        if (max_val < 1023) val = val | ($urandom_range(0, 3) << GAIN_BITS);
        return CFG_DATA_BITS'(val);
    endfunction

    // wait until every pending command has come back
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic reg_write(input t_cfg_idx idx, input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_THRESHOLD: thr_q  = data[SAMPLE_BITS-1:0];
            CFG_BASE:      base_q = data[GAIN_BITS-1:0];
            CFG_KP:        kp_q   = data[GAIN_BITS-1:0];
            CFG_KD:        kd_q   = data[GAIN_BITS-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [CFG_DATA_BITS-1:0] thr,
                                input logic [CFG_DATA_BITS-1:0] base,
                                input logic [CFG_DATA_BITS-1:0] kp,
                                input logic [CFG_DATA_BITS-1:0] kd);
        drain();
        reg_write(CFG_THRESHOLD, thr);
        reg_write(CFG_BASE, base);
        reg_write(CFG_KP, kp);
        reg_write(CFG_KD, kd);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] rs,
                               input logic [SAMPLE_BITS-1:0] ls,
                               input bit known, input t_motor_cmd typed);
        t_motor_cmd want;
        want = follow_step(rs, ls);
        if (known) want = typed;
        if (src_idle_en && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(IN_TDATA_BITS - 2 * SAMPLE_BITS){1'b0}}, ls, rs};
        pending_cmds.push_back(want);
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // result side: check each beat, stall in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got_cmd = o_m_tdata[$bits(t_motor_cmd)-1:0];
                if (pending_cmds.size() == 0) begin
                    $error("result beat with no command pending: %h", got_cmd);
                    failed = 1'b1;
                end else begin
                    want_cmd = pending_cmds.pop_front();
                    if (got_cmd.right_drive !== want_cmd.right_drive) begin
                        $error("right_drive: expected %0d, got %0d",
                               $signed(want_cmd.right_drive), $signed(got_cmd.right_drive));
                        failed = 1'b1;
                    end
                    if (got_cmd.left_drive !== want_cmd.left_drive) begin
                        $error("left_drive: expected %0d, got %0d",
                               $signed(want_cmd.left_drive), $signed(got_cmd.left_drive));
                        failed = 1'b1;
                    end
                    if (got_cmd.track_error !== want_cmd.track_error) begin
                        $error("track_error: expected %0d, got %0d",
                               $signed(want_cmd.track_error), $signed(got_cmd.track_error));
                        failed = 1'b1;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (snk_stall_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 6);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("pd_tape_follower_top_test: FAIL");
                $finish;
            end
        end
    end

    initial begin
        int        ph;
        int        cnt;
        int        run;
        bit        r_off;
        bit        l_off;
        bit        noise;
        bit        paused;
        t_stim_row row;
        logic [SAMPLE_BITS-1:0] rs;
        logic [SAMPLE_BITS-1:0] ls;

        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_THRESHOLD;
        i_cfg_data <= '0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        thr_q = '0;
        base_q = '0;
        kp_q = '0;
        kd_q = '0;
        prev_err = 0;
        ref_err = 0;
        last_side = 0;
        hold_cnt = 0;
        paused = 1'b0;
        src_idle_en = 1'b1;
        snk_stall_en = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG) begin
                if (i == 0) drain();
                else if (dir_rows[i-1].kind != ROW_CFG) drain();
                reg_write(t_cfg_idx'(row.a[CFG_IDX_BITS-1:0]), row.b);
                if (i == DIR_ROWS - 1) i_cfg_we <= 1'b0;
                else if (dir_rows[i+1].kind != ROW_CFG) i_cfg_we <= 1'b0;
            end else begin
                send_sample(row.a, row.b, row.known, {row.er, row.ld, row.rd});
            end
        end

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph == 0) program_regs(10'd1023, 10'd255, 10'd255, 10'd255);
            else if (ph == 1) program_regs(10'd0, 10'd0, 10'd0, 10'd0);
            else program_regs(pick_reg(1023), pick_reg(255), pick_reg(255), pick_reg(255));
            snk_stall_en = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
            cnt = 0;
            while (cnt < PHASE_ITEMS) begin
                r_off = $urandom_range(0, 1);
                l_off = $urandom_range(0, 1);
                run = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
                src_idle_en = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
                repeat (run) begin
                    noise = ($urandom_range(0, 9) == 0);
                    rs = noise ? SAMPLE_BITS'($urandom_range(0, 1023)) : pick_sample(r_off);
                    ls = noise ? SAMPLE_BITS'($urandom_range(0, 1023)) : pick_sample(l_off);
                    send_sample(rs, ls, 1'b0, '0);
                    cnt++;
                end
                if (ph == 3 && !paused && cnt > PHASE_ITEMS / 2) begin
                    i_s_tvalid <= 1'b0;
                    while (pending_cmds.size() != 0) @(posedge i_clk);
                    paused = 1'b1;
                end
            end
        end

        // steady run: constant error, hold count keeps growing
        src_idle_en = 1'b0;
        snk_stall_en = 1'b0;
        program_regs(10'd512, 10'd0, 10'd0, 10'd255);
        send_sample(10'd1023, 10'd1023, 1'b0, '0);
        repeat (SOAK_ITEMS) send_sample(pick_sample(1'b1), pick_sample(1'b0), 1'b0, '0);

        i_s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (!failed) begin
            $display("pd_tape_follower_top_test: PASS");
        end else begin
            $display("pd_tape_follower_top_test: FAIL");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/pdtf_pkg.sv
hw/rtl/pdtf_divider.sv
hw/rtl/pd_tape_follower_top.sv
bench/pd_tape_follower_top_test.sv
